// File: rtl/core/perspective_point_projection_assert.svh
// Assertion macros used by perspective_point_projection.
`ifndef PERSPECTIVE_POINT_PROJECTION_ASSERT_SVH
`define PERSPECTIVE_POINT_PROJECTION_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define PPP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define PPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg
// Types and constants for the perspective point projection block.
// ----------------------------------------------------------------------------
package ppp_pkg;

    localparam int COORD_BITS     = 16;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int CFG_BITS       = 16;
    localparam int CFG_IDX_BITS   = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_SIN_THETA       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COS_THETA       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIN_PHI         = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_COS_PHI         = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_RADIUS     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_DISTANCE = 3'd5;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic signed [COORD_BITS-1:0] vertex_z;
    } vertex_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] screen_x;
        logic signed [COORD_BITS-1:0] screen_y;
        logic                         behind_eye;
    } screen_t;

endpackage

// File: rtl/core/perspective_point_projection.sv
// ----------------------------------------------------------------------------
// perspective_point_projection
// Rotates a vertex into view space, divides by depth, rounds and saturates.
// ----------------------------------------------------------------------------
// One vertex per cycle in, one screen point per cycle out, while not stalled.
// Six stages form the rotation products, the view sums and the scaled
// numerators; a 17-stage restoring divider (one overflow check, then one
// quotient bit per stage, x and y side by side) gives the rounded quotient,
// then a registered output. The whole pipe advances when the output register
// is empty or taken, so a stall holds every stage in place. Configuration
// writes take effect at once and must be made while the pipe is empty.
module perspective_point_projection
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ppp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ppp_pkg::CFG_BITS-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ppp_pkg::vertex_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ppp_pkg::screen_t                    out_data
);
    import ppp_pkg::*;

    localparam int PW    = 2 * COORD_BITS;           // trig x coord product
    localparam int AW    = PW + 1;                   // vx before 2^F scale
    localparam int MW    = PW + COORD_BITS;          // triple product
    localparam int VW    = MW + 2;                   // vy, vz
    localparam int SPLIT = VW / 2;
    localparam int LOW   = SPLIT + CFG_BITS + 1;
    localparam int HIW   = VW - SPLIT + CFG_BITS + 1;
    localparam int NW    = VW + CFG_BITS + TRIG_FRAC_BITS;
    localparam int DENW  = VW + 1;
    localparam int REMW  = NW + COORD_BITS + 4;
    localparam int NDIV  = COORD_BITS + 1;
    localparam int NSTG  = 6 + NDIV + 1;

    typedef struct packed {
        logic [REMW-1:0]       rem_x;
        logic [REMW-1:0]       rem_y;
        logic [COORD_BITS-1:0] q_x;
        logic [COORD_BITS-1:0] q_y;
        logic                  hi_x;
        logic                  lo_x;
        logic                  hi_y;
        logic                  lo_y;
        logic [DENW-1:0]       den;
        logic                  behind;
    } div_stage_t;

    logic signed [CFG_BITS-1:0] sin_theta_reg, cos_theta_reg, sin_phi_reg, cos_phi_reg;
    logic [CFG_BITS-1:0]        view_radius_reg, screen_distance_reg;

    logic [NSTG-1:0] vld_reg;
    logic            en;

    // stage 1
    logic signed [PW-1:0] stx_reg, cty_reg, ctcp_reg, stcp_reg, ctsp_reg, stsp_reg;
    logic signed [PW-1:0] spz_reg, cpz_reg;
    logic signed [COORD_BITS-1:0] x1_reg, y1_reg;
    // stage 2
    logic signed [AW-1:0] a2_reg;
    logic signed [MW-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [PW-1:0] spz2_reg, cpz2_reg;
    // stage 3
    logic signed [AW-1:0] a3_reg;
    logic signed [VW-1:0] vy3_reg, vz3_reg;
    // stage 4
    logic signed [VW-1:0] nx4_reg;
    logic [LOW-1:0]       ylo4_reg;
    logic signed [HIW-1:0] yhi4_reg;
    logic signed [VW-1:0] q4_reg;
    logic                 behind4_reg;
    // stage 5
    logic signed [NW-1:0] nx5_reg, ny5_reg;
    logic signed [VW-1:0] q5_reg;
    logic                 behind5_reg;
    // stage 6
    logic signed [REMW-1:0] mx6_reg, my6_reg;
    logic [DENW-1:0]        den6_reg;
    logic                   behind6_reg;
    // divider
    div_stage_t div_reg [NDIV];
    div_stage_t div_next [NDIV];
    screen_t    out_reg;

    logic signed [CFG_BITS:0] d_s;
    assign d_s = $signed({1'b0, screen_distance_reg});

    assign en        = !vld_reg[NSTG-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NSTG-1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sin_theta_reg       <= -16'sd16384;
            cos_theta_reg       <= 16'sd0;
            sin_phi_reg         <= 16'sd0;
            cos_phi_reg         <= 16'sd16384;
            view_radius_reg     <= 16'd800;
            screen_distance_reg <= 16'd1000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SIN_THETA:       sin_theta_reg       <= cfg_data;
                REG_COS_THETA:       cos_theta_reg       <= cfg_data;
                REG_SIN_PHI:         sin_phi_reg         <= cfg_data;
                REG_COS_PHI:         cos_phi_reg         <= cfg_data;
                REG_VIEW_RADIUS:     view_radius_reg     <= cfg_data;
                REG_SCREEN_DISTANCE: screen_distance_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
    end

    // divider stages: stage 0 checks overflow, stage k gives bit NDIV-1-k
    always_comb
    begin
        div_next[0].rem_x  = mx6_reg;
        div_next[0].rem_y  = my6_reg;
        div_next[0].q_x    = '0;
        div_next[0].q_y    = '0;
        div_next[0].lo_x   = mx6_reg[REMW-1];
        div_next[0].lo_y   = my6_reg[REMW-1];
        div_next[0].hi_x   = !mx6_reg[REMW-1]
                             && (mx6_reg >= (REMW'(den6_reg) << COORD_BITS));
        div_next[0].hi_y   = !my6_reg[REMW-1]
                             && (my6_reg >= (REMW'(den6_reg) << COORD_BITS));
        div_next[0].den    = den6_reg;
        div_next[0].behind = behind6_reg;
        for (int k = 1; k < NDIV; k++)
        begin
            div_next[k] = div_reg[k-1];
            if (!div_reg[k-1].hi_x && !div_reg[k-1].lo_x
                && (div_reg[k-1].rem_x >= (REMW'(div_reg[k-1].den) << (NDIV - 1 - k))))
            begin
                div_next[k].rem_x = div_reg[k-1].rem_x
                                    - (REMW'(div_reg[k-1].den) << (NDIV - 1 - k));
                div_next[k].q_x[NDIV-1-k] = 1'b1;
            end
            if (!div_reg[k-1].hi_y && !div_reg[k-1].lo_y
                && (div_reg[k-1].rem_y >= (REMW'(div_reg[k-1].den) << (NDIV - 1 - k))))
            begin
                div_next[k].rem_y = div_reg[k-1].rem_y
                                    - (REMW'(div_reg[k-1].den) << (NDIV - 1 - k));
                div_next[k].q_y[NDIV-1-k] = 1'b1;
            end
        end
    end

    function automatic logic [COORD_BITS-1:0] final_coord(logic [COORD_BITS-1:0] q,
                                                          logic hi, logic lo, logic behind);
        logic [COORD_BITS-1:0] r;
        if (behind)
            r = '0;
        else if (hi)
            r = {1'b0, {(COORD_BITS-1){1'b1}}};
        else if (lo)
            r = {1'b1, {(COORD_BITS-1){1'b0}}};
        else
            r = {~q[COORD_BITS-1], q[COORD_BITS-2:0]};   // remove 2^(N-1) bias
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: trig x coord and trig x trig products
            stx_reg  <= PW'(sin_theta_reg) * PW'(in_data.vertex_x);
            cty_reg  <= PW'(cos_theta_reg) * PW'(in_data.vertex_y);
            ctcp_reg <= PW'(cos_theta_reg) * PW'(cos_phi_reg);
            stcp_reg <= PW'(sin_theta_reg) * PW'(cos_phi_reg);
            ctsp_reg <= PW'(cos_theta_reg) * PW'(sin_phi_reg);
            stsp_reg <= PW'(sin_theta_reg) * PW'(sin_phi_reg);
            spz_reg  <= PW'(sin_phi_reg) * PW'(in_data.vertex_z);
            cpz_reg  <= PW'(cos_phi_reg) * PW'(in_data.vertex_z);
            x1_reg   <= in_data.vertex_x;
            y1_reg   <= in_data.vertex_y;

            // stage 2
            a2_reg   <= AW'(cty_reg) - AW'(stx_reg);
            m1_reg   <= MW'(ctcp_reg) * MW'(x1_reg);
            m2_reg   <= MW'(stcp_reg) * MW'(y1_reg);
            m3_reg   <= MW'(ctsp_reg) * MW'(x1_reg);
            m4_reg   <= MW'(stsp_reg) * MW'(y1_reg);
            spz2_reg <= spz_reg;
            cpz2_reg <= cpz_reg;

            // stage 3: view depth carries R at scale 2^(2F)
            a3_reg  <= a2_reg;
            vy3_reg <= (VW'(spz2_reg) <<< TRIG_FRAC_BITS) - VW'(m1_reg) - VW'(m2_reg);
            vz3_reg <= $signed(VW'(view_radius_reg) << (2 * TRIG_FRAC_BITS))
                       - VW'(m3_reg) - VW'(m4_reg) - (VW'(cpz2_reg) <<< TRIG_FRAC_BITS);

            // stage 4: scale by d, vy split in two partial products
            nx4_reg     <= VW'(a3_reg) * VW'(d_s);
            ylo4_reg    <= LOW'(vy3_reg[SPLIT-1:0]) * LOW'(screen_distance_reg);
            yhi4_reg    <= HIW'($signed(vy3_reg[VW-1:SPLIT])) * HIW'(d_s);
            q4_reg      <= vz3_reg;
            behind4_reg <= vz3_reg[VW-1] || (vz3_reg == '0);

            // stage 5
            nx5_reg     <= NW'(nx4_reg) <<< TRIG_FRAC_BITS;
            ny5_reg     <= (NW'(yhi4_reg) <<< SPLIT) + $signed(NW'(ylo4_reg));
            q5_reg      <= q4_reg;
            behind5_reg <= behind4_reg;

            // stage 6: floor(n/q + 1/2) = floor((2n+q)/2q), biased by 2^(N-1)
            mx6_reg     <= (REMW'(nx5_reg) <<< 1) + REMW'(q5_reg)
                           + (REMW'(q5_reg) <<< COORD_BITS);
            my6_reg     <= (REMW'(ny5_reg) <<< 1) + REMW'(q5_reg)
                           + (REMW'(q5_reg) <<< COORD_BITS);
            den6_reg    <= {q5_reg[VW-1:0], 1'b0};
            behind6_reg <= behind5_reg;

            for (int k = 0; k < NDIV; k++)
            begin
                div_reg[k] <= div_next[k];
            end

            out_reg.screen_x   <= final_coord(div_reg[NDIV-1].q_x, div_reg[NDIV-1].hi_x,
                                              div_reg[NDIV-1].lo_x, div_reg[NDIV-1].behind);
            out_reg.screen_y   <= final_coord(div_reg[NDIV-1].q_y, div_reg[NDIV-1].hi_y,
                                              div_reg[NDIV-1].lo_y, div_reg[NDIV-1].behind);
            out_reg.behind_eye <= div_reg[NDIV-1].behind;
        end
    end

`include "perspective_point_projection_assert.svh"

    `PPP_ASSERT_IMPL(a_behind_zero, out_valid && out_data.behind_eye, out_data.screen_x == '0 && out_data.screen_y == '0, "behind eye with nonzero coordinates")
    `PPP_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_reg), "pipeline moved during stall")
    `PPP_ASSERT_IMPL(a_sat_excl, vld_reg[NSTG-2], !(div_reg[NDIV-1].hi_x && div_reg[NDIV-1].lo_x) && !(div_reg[NDIV-1].hi_y && div_reg[NDIV-1].lo_y), "both saturation flags set")

endmodule
